// ===== rtl/fpbt_pkg.sv =====
package fpbt_pkg;

   localparam int ADDR_W    = 48;
   localparam int ADDR_BITS = 48;
   localparam int ENT_W     = 5;
   localparam int SHIFT_W   = 5;
   localparam int KIND_W    = 2;
   localparam int CSR_IDX_W = 2;

   // Addresses are kept to ADDR_BITS bits inside the 48-bit fields
   localparam logic [ADDR_W-1:0] ADDR_MASK = (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} :
      ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

   typedef logic [KIND_W-1:0] kind_type;

   localparam kind_type KIND_HIT   = 2'd0;
   localparam kind_type KIND_FILL  = 2'd1;
   localparam kind_type KIND_EVICT = 2'd2;
   localparam kind_type KIND_DONE  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_ENTRIES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE    = 2'd2;

   localparam logic [ENT_W-1:0]   ENTRIES_RESET = 5'd16;
   localparam logic [SHIFT_W-1:0] SHIFT_RESET   = 5'd12;

   typedef struct packed {
      logic     capture;
      logic     out_load;
      kind_type out_kind;
      logic     rd_scan;
      logic     evict_clear;
      logic     fill;
      logic     hit_mark;
      logic     scan_adv;
   } cmd_type;

   typedef struct packed {
      logic is_flush;
      logic hit;
      logic ptr_valid;
      logic scan_valid;
      logic scan_last;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/fpbt_ctrl.sv =====
module fpbt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  fpbt_pkg::status_type status,
   output fpbt_pkg::cmd_type    cmd
);
   import fpbt_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_LOOK  = 3'd1;
   localparam logic [2:0] S_FILL  = 3'd2;
   localparam logic [2:0] S_FLUSH = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      cmd          = '0;
      cmd.out_kind = KIND_HIT;
      state_in     = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_LOOK;
            end
         end
         S_LOOK: begin
            if (status.is_flush) begin
               state_in = S_FLUSH;
            end else if (status.out_free) begin
               cmd.out_load = 1'b1;
               if (status.hit) begin
                  cmd.out_kind = KIND_HIT;
                  cmd.hit_mark = 1'b1;
                  state_in     = S_IDLE;
               end else if (status.ptr_valid) begin
                  cmd.out_kind = KIND_EVICT;
                  state_in     = S_FILL;
               end else begin
                  cmd.out_kind = KIND_FILL;
                  cmd.fill     = 1'b1;
                  state_in     = S_IDLE;
               end
            end
         end
         S_FILL: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = KIND_FILL;
               cmd.fill     = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_FLUSH: begin
            cmd.rd_scan = 1'b1;
            // occupied slot: wait for the output register, then evict it
            if (!status.scan_valid || status.out_free) begin
               if (status.scan_valid) begin
                  cmd.out_load    = 1'b1;
                  cmd.out_kind    = KIND_EVICT;
                  cmd.evict_clear = 1'b1;
               end
               if (status.scan_last) begin
                  state_in = S_DONE;
               end else begin
                  cmd.scan_adv = 1'b1;
               end
            end
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = KIND_DONE;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/fpbt_dp.sv =====
module fpbt_dp #(
   parameter int BUF_DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  fpbt_pkg::cmd_type                    cmd,
   output fpbt_pkg::status_type                 status,
   input  logic                                 req_opcode,
   input  logic [fpbt_pkg::ADDR_W-1:0]          req_fault_address,
   input  logic                                 req_protect_fault,
   input  logic                                 req_write_fault,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [fpbt_pkg::KIND_W-1:0]          rsp_result_kind,
   output logic [fpbt_pkg::ADDR_W-1:0]          rsp_page_base,
   output logic [fpbt_pkg::ADDR_W-1:0]          rsp_backing_offset,
   output logic                                 rsp_write_access,
   output logic                                 rsp_writeback,
   output logic                                 rsp_last,
   input  logic                                 csr_valid,
   input  logic [fpbt_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [fpbt_pkg::ADDR_W-1:0]          csr_data
);
   import fpbt_pkg::*;

   localparam int PTR_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
   localparam int CNT_W = $clog2(BUF_DEPTH + 1);
   localparam int CMP_W = ((CNT_W > ENT_W) ? CNT_W : ENT_W) + 1;

   // configuration
   logic [ENT_W-1:0]   entries_ff;
   logic [SHIFT_W-1:0] shift_ff;
   logic [ADDR_W-1:0]  base_ff;

   // captured request
   logic              flush_ff;
   logic [ADDR_W-1:0] page_ff;
   logic              wa_ff;

   // slot table
   logic [ADDR_W-1:0]    slot_page_ff [BUF_DEPTH];
   logic [BUF_DEPTH-1:0] valid_ff;
   logic [BUF_DEPTH-1:0] valid_in;
   logic [BUF_DEPTH-1:0] dirty_ff;
   logic [BUF_DEPTH-1:0] dirty_in;
   logic [BUF_DEPTH-1:0] hit_vec;

   logic [PTR_W-1:0] fill_ptr_ff;
   logic [PTR_W-1:0] scan_ff;

   // output register
   logic              out_valid_ff;
   kind_type          out_kind_ff;
   logic [ADDR_W-1:0] out_page_ff;
   logic [ADDR_W-1:0] out_offset_ff;
   logic              out_wa_ff;
   logic              out_wb_ff;
   logic              out_last_ff;

   logic [CMP_W-1:0]  ent_ext;
   logic [CMP_W-1:0]  eff_ent;
   logic [CMP_W-1:0]  ptr_inc;
   logic [PTR_W-1:0]  ptr_use;
   logic [PTR_W-1:0]  ptr_next;
   logic [PTR_W-1:0]  rd_idx;
   logic [ADDR_W-1:0] out_page;
   logic [ADDR_W-1:0] out_offset;
   logic              out_wa;
   logic              out_wb;
   logic              out_last;
   logic              out_free;

   // pointer wraps modulo the effective entry count
   always_comb begin
      ent_ext = CMP_W'(entries_ff);
      if (ent_ext == '0) begin
         eff_ent = CMP_W'(1);
      end else if (ent_ext > CMP_W'(BUF_DEPTH)) begin
         eff_ent = CMP_W'(BUF_DEPTH);
      end else begin
         eff_ent = ent_ext;
      end
      ptr_use  = (CMP_W'(fill_ptr_ff) >= eff_ent) ? '0 : fill_ptr_ff;
      ptr_inc  = CMP_W'(ptr_use) + CMP_W'(1);
      ptr_next = (ptr_inc >= eff_ent) ? '0 : PTR_W'(ptr_inc);
      rd_idx   = cmd.rd_scan ? scan_ff : ptr_use;
   end

   always_comb begin
      for (int i = 0; i < BUF_DEPTH; i++) begin
         hit_vec[i] = valid_ff[i] && (slot_page_ff[i] == page_ff);
      end
   end

   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      status.is_flush   = flush_ff;
      status.hit        = |hit_vec;
      status.ptr_valid  = valid_ff[ptr_use];
      status.scan_valid = valid_ff[scan_ff];
      status.scan_last  = (scan_ff == PTR_W'(BUF_DEPTH - 1));
      status.out_free   = out_free;
   end

   always_comb begin
      valid_in = valid_ff;
      dirty_in = dirty_ff;
      if (cmd.hit_mark && wa_ff) begin
         dirty_in = dirty_ff | hit_vec;
      end
      if (cmd.fill) begin
         valid_in[ptr_use] = 1'b1;
         dirty_in[ptr_use] = wa_ff;
      end
      if (cmd.evict_clear) begin
         valid_in[scan_ff] = 1'b0;
         dirty_in[scan_ff] = 1'b0;
      end
   end

   always_comb begin
      out_page = page_ff;
      out_wa   = wa_ff;
      out_wb   = 1'b0;
      out_last = 1'b1;
      case (cmd.out_kind)
         KIND_EVICT: begin
            out_page = slot_page_ff[rd_idx];
            out_wa   = 1'b0;
            out_wb   = dirty_ff[rd_idx];
            out_last = 1'b0;
         end
         KIND_DONE: begin
            out_page = '0;
            out_wa   = 1'b0;
         end
         default: begin
         end
      endcase
      out_offset = (out_page - base_ff) & ADDR_MASK;
      if (cmd.out_kind == KIND_DONE) begin
         out_offset = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff   <= ENTRIES_RESET;
         shift_ff     <= SHIFT_RESET;
         base_ff      <= '0;
         valid_ff     <= '0;
         dirty_ff     <= '0;
         fill_ptr_ff  <= '0;
         scan_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_ENTRIES: entries_ff <= csr_data[ENT_W-1:0];
               CSR_SHIFT:   shift_ff   <= csr_data[SHIFT_W-1:0];
               CSR_BASE:    base_ff    <= csr_data;
               default: begin
               end
            endcase
         end
         valid_ff <= valid_in;
         dirty_ff <= dirty_in;
         if (cmd.fill) begin
            fill_ptr_ff <= ptr_next;
         end
         if (cmd.capture) begin
            scan_ff <= '0;
         end else if (cmd.scan_adv) begin
            scan_ff <= scan_ff + PTR_W'(1);
         end
         if (cmd.out_load) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         flush_ff <= req_opcode;
         page_ff  <= req_fault_address & ({ADDR_W{1'b1}} << shift_ff) & ADDR_MASK;
         wa_ff    <= req_protect_fault | req_write_fault;
      end
      if (cmd.fill) begin
         slot_page_ff[ptr_use] <= page_ff;
      end
      if (cmd.out_load) begin
         out_kind_ff   <= cmd.out_kind;
         out_page_ff   <= out_page;
         out_offset_ff <= out_offset;
         out_wa_ff     <= out_wa;
         out_wb_ff     <= out_wb;
         out_last_ff   <= out_last;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_result_kind    = out_kind_ff;
   assign rsp_page_base      = out_page_ff;
   assign rsp_backing_offset = out_offset_ff;
   assign rsp_write_access   = out_wa_ff;
   assign rsp_writeback      = out_wb_ff;
   assign rsp_last           = out_last_ff;

endmodule

// ===== rtl/fifo_page_buffer_tracker_unit.sv =====
// Channel   Handshake             Beat contents
// req       req_valid/req_stall   opcode, fault_address, protect_fault, write_fault
// rsp       rsp_valid/rsp_stall   result_kind, page_base, backing_offset,
//                                 write_access, writeback, last
// csr       csr_valid/csr_ready   csr_index, csr_data
//
// One item at a time. A hit or a fill into an empty slot is answered in S_LOOK;
// an eviction sends its evict beat there and the fill beat from S_FILL. A flush
// scans one slot per cycle through the single slot read port, then sends done.
// Synchronous reset empties the table, zeroes the fill pointer and loads the
// register defaults. A stall on rsp holds the output register and pauses the
// sequencer; req_stall is high from acceptance until the last beat is loaded.
module fifo_page_buffer_tracker_unit #(
   parameter int BUF_DEPTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_opcode,
   input  logic [fpbt_pkg::ADDR_W-1:0]    req_fault_address,
   input  logic                           req_protect_fault,
   input  logic                           req_write_fault,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [fpbt_pkg::KIND_W-1:0]    rsp_result_kind,
   output logic [fpbt_pkg::ADDR_W-1:0]    rsp_page_base,
   output logic [fpbt_pkg::ADDR_W-1:0]    rsp_backing_offset,
   output logic                           rsp_write_access,
   output logic                           rsp_writeback,
   output logic                           rsp_last,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [fpbt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fpbt_pkg::ADDR_W-1:0]    csr_data
);
   import fpbt_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   fpbt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   fpbt_dp #(
      .BUF_DEPTH (BUF_DEPTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_opcode         (req_opcode),
      .req_fault_address  (req_fault_address),
      .req_protect_fault  (req_protect_fault),
      .req_write_fault    (req_write_fault),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_page_base      (rsp_page_base),
      .rsp_backing_offset (rsp_backing_offset),
      .rsp_write_access   (rsp_write_access),
      .rsp_writeback      (rsp_writeback),
      .rsp_last           (rsp_last),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

endmodule

// ===== tb/sv/fifo_page_buffer_tracker_unit_test.sv =====
`timescale 1ns / 100ps

module fifo_page_buffer_tracker_unit_test;
   import fpbt_pkg::*;

   localparam int DEPTH = 16;
   localparam logic OP_FAULT = 1'b0;
   localparam logic OP_FLUSH = 1'b1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int SETTLE_CYCLES = DEPTH + 10;

   typedef struct packed {
      kind_type          kind;
      logic [ADDR_W-1:0] page;
      logic [ADDR_W-1:0] offset;
      logic              write_access;
      logic              writeback;
      logic              last;
   } page_result_type;

   // Shadow of the resident page table; predicts the beats each request produces.
   class resident_page_scoreboard;
      logic [ADDR_W-1:0]  slot_page [DEPTH];
      bit                 slot_valid [DEPTH];
      bit                 slot_dirty [DEPTH];
      int unsigned        fill_ptr;
      logic [ENT_W-1:0]   entries;
      logic [SHIFT_W-1:0] shift;
      logic [ADDR_W-1:0]  region_base;
      page_result_type    pending_results [$];
      int unsigned        mismatches;

      function new();
         for (int i = 0; i < DEPTH; i++) begin
            slot_page[i]  = '0;
            slot_valid[i] = 1'b0;
            slot_dirty[i] = 1'b0;
         end
         fill_ptr    = 0;
         entries     = ENTRIES_RESET;
         shift       = SHIFT_RESET;
         region_base = '0;
         mismatches  = 0;
      endfunction

      function void note_config(logic [CSR_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
         case (idx)
            CSR_ENTRIES: entries = data[ENT_W-1:0];
            CSR_SHIFT:   shift = data[SHIFT_W-1:0];
            CSR_BASE:    region_base = data;
            default: ;
         endcase
      endfunction

      function void push_beat(kind_type kind, logic [ADDR_W-1:0] page, bit wa, bit wb,
                              bit last);
         page_result_type r;
         r.kind         = kind;
         r.page         = page;
         r.offset       = (kind == KIND_DONE) ? '0 : ((page - region_base) & ADDR_MASK);
         r.write_access = wa;
         r.writeback    = wb;
         r.last         = last;
         pending_results.push_back(r);
      endfunction

      function int unsigned active_entries();
         if (entries == 0) return 1;
         if (entries > DEPTH) return DEPTH;
         return entries;
      endfunction

      function void note_request(logic op, logic [ADDR_W-1:0] addr, logic prot, logic wr);
         logic [63:0]       pmask;
         logic [ADDR_W-1:0] page;
         bit                wa;
         int unsigned       ent;
         int unsigned       ptr;
         if (op == OP_FLUSH) begin
            for (int i = 0; i < DEPTH; i++) begin
               if (slot_valid[i]) begin
                  push_beat(KIND_EVICT, slot_page[i], 1'b0, slot_dirty[i], 1'b0);
                  slot_valid[i] = 1'b0;
                  slot_dirty[i] = 1'b0;
               end
            end
            push_beat(KIND_DONE, '0, 1'b0, 1'b0, 1'b1);
            return;
         end
         pmask = ~((64'd1 << shift) - 64'd1);
         page  = addr & pmask[ADDR_W-1:0] & ADDR_MASK;
         wa    = prot | wr;
         ent   = active_entries();
         for (int i = 0; i < DEPTH; i++) begin
            if (slot_valid[i] && slot_page[i] == page) begin
               if (wa) slot_dirty[i] = 1'b1;
               push_beat(KIND_HIT, page, wa, 1'b0, 1'b1);
               return;
            end
         end
         // a pointer left past a shrunken window restarts at slot zero
         ptr = (fill_ptr >= ent) ? 0 : fill_ptr;
         if (slot_valid[ptr]) push_beat(KIND_EVICT, slot_page[ptr], 1'b0, slot_dirty[ptr], 1'b0);
         slot_page[ptr]  = page;
         slot_valid[ptr] = 1'b1;
         slot_dirty[ptr] = wa;
         push_beat(KIND_FILL, page, wa, 1'b0, 1'b1);
         ptr      = ptr + 1;
         fill_ptr = (ptr >= ent) ? 0 : ptr;
      endfunction

      function void compare_field(string name, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
         if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(page_result_type got);
         page_result_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected beat expected none actual kind %0d page %h",
                     $time, got.kind, got.page);
            mismatches++;
            return;
         end
         want = pending_results.pop_front();
         compare_field("result_kind", ADDR_W'(want.kind), ADDR_W'(got.kind));
         compare_field("page_base", want.page, got.page);
         compare_field("backing_offset", want.offset, got.offset);
         compare_field("write_access", ADDR_W'(want.write_access), ADDR_W'(got.write_access));
         compare_field("writeback", ADDR_W'(want.writeback), ADDR_W'(got.writeback));
         compare_field("last", ADDR_W'(want.last), ADDR_W'(got.last));
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic                 req_opcode;
   logic [ADDR_W-1:0]    req_fault_address;
   logic                 req_protect_fault;
   logic                 req_write_fault;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [KIND_W-1:0]    rsp_result_kind;
   logic [ADDR_W-1:0]    rsp_page_base;
   logic [ADDR_W-1:0]    rsp_backing_offset;
   logic                 rsp_write_access;
   logic                 rsp_writeback;
   logic                 rsp_last;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [ADDR_W-1:0]    csr_data;
   bit                   quiet;

   resident_page_scoreboard tracker;

   fifo_page_buffer_tracker_unit #(
      .BUF_DEPTH (DEPTH)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_fault_address  (req_fault_address),
      .req_protect_fault  (req_protect_fault),
      .req_write_fault    (req_write_fault),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_page_base      (rsp_page_base),
      .rsp_backing_offset (rsp_backing_offset),
      .rsp_write_access   (rsp_write_access),
      .rsp_writeback      (rsp_writeback),
      .rsp_last           (rsp_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("Mismatches found");
      $finish;
   end

   // Receiver back-pressure in random bursts; none once the run goes quiet.
   initial begin : rsp_backpressure
      int unsigned span;
      bit          hold;
      rsp_stall = 1'b0;
      forever begin
         span = $urandom_range(1, 16);
         hold = ($urandom_range(0, 2) == 0);
         repeat (span) begin
            @(negedge clock);
            rsp_stall <= hold && !quiet;
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      page_result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.kind         = rsp_result_kind;
         got.page         = rsp_page_base;
         got.offset       = rsp_backing_offset;
         got.write_access = rsp_write_access;
         got.writeback    = rsp_writeback;
         got.last         = rsp_last;
         tracker.check_result(got);
      end
   end

   function automatic logic [ADDR_W-1:0] rand48();
      return {16'($urandom), 32'($urandom)};
   endfunction

   // Called at a falling edge; returns at the falling edge after the beat is taken,
   // leaving valid high so a following beat can go out back to back.
   task automatic send_item(logic op, logic [ADDR_W-1:0] addr, logic prot, logic wr);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_opcode        <= op;
      req_fault_address <= addr;
      req_protect_fault <= prot;
      req_write_fault   <= wr;
      do @(posedge clock); while (req_stall);
      tracker.note_request(op, addr, prot, wr);
      @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      tracker.note_config(idx, data);
      @(negedge clock);
   endtask

   task automatic wait_for_idle();
      while (tracker.pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic configure(logic [ENT_W-1:0] ent, logic [SHIFT_W-1:0] shf,
                            logic [ADDR_W-1:0] base);
      req_valid <= 1'b0;
      wait_for_idle();
      write_csr(CSR_ENTRIES, ADDR_W'(ent));
      write_csr(CSR_SHIFT, ADDR_W'(shf));
      write_csr(CSR_BASE, base);
      csr_valid <= 1'b0;
   endtask

   // Faults mostly land in a small set of pages so hits, evictions and refills mix.
   task automatic run_phase(int count);
      logic [ADDR_W-1:0] pool [12];
      logic [63:0]       low_mask;
      int unsigned       pool_n;
      int unsigned       roll;
      pool_n   = $urandom_range(2, 12);
      low_mask = (64'd1 << tracker.shift) - 64'd1;
      for (int i = 0; i < 12; i++) pool[i] = rand48();
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 5)
            send_item(OP_FLUSH, rand48(), 1'($urandom), 1'($urandom));
         else if (roll < 12)
            send_item(OP_FAULT, rand48(), 1'($urandom), 1'($urandom));
         else
            send_item(OP_FAULT,
                      pool[$urandom_range(0, pool_n - 1)] ^ (rand48() & low_mask[ADDR_W-1:0]),
                      1'($urandom), 1'($urandom));
      end
   endtask

   initial begin
      tracker           = new();
      quiet             = 1'b0;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_opcode        = OP_FAULT;
      req_fault_address = '0;
      req_protect_fault = 1'b0;
      req_write_fault   = 1'b0;
      csr_valid         = 1'b0;
      csr_index         = CSR_ENTRIES;
      csr_data          = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // spare index must leave every register untouched
      write_csr(CSR_SPARE, rand48());
      csr_valid <= 1'b0;
      @(negedge clock);

      // default registers: empty flush, hits with and without write, address extremes
      send_item(OP_FLUSH, '0, 1'b0, 1'b0);
      send_item(OP_FAULT, 48'h0000_0000_0000, 1'b0, 1'b0);
      send_item(OP_FAULT, 48'h0000_0000_0FFF, 1'b0, 1'b1);
      send_item(OP_FAULT, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0);
      send_item(OP_FAULT, 48'h8000_0000_0000, 1'b0, 1'b0);
      send_item(OP_FAULT, 48'h0000_1234_5678, 1'b1, 1'b1);
      send_item(OP_FAULT, 48'h0000_1234_5000, 1'b0, 1'b0);
      send_item(OP_FLUSH, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b1);
      // park pages in slots four to seven
      send_item(OP_FAULT, 48'h0000_0000_1000, 1'b0, 1'b0);
      send_item(OP_FAULT, 48'h0000_0000_2000, 1'b0, 1'b1);
      send_item(OP_FAULT, 48'h0000_0000_3000, 1'b0, 1'b0);
      send_item(OP_FAULT, 48'h0000_0000_4000, 1'b1, 1'b0);

      // shrink the window under a far pointer; base above some pages wraps offsets
      configure(5'd2, 5'd12, 48'h0000_0000_2000);
      send_item(OP_FAULT, 48'h0000_0000_4ABC, 1'b0, 1'b0);
      send_item(OP_FAULT, 48'h0000_0000_5000, 1'b0, 1'b0);
      send_item(OP_FAULT, 48'h0000_0000_6000, 1'b0, 1'b1);
      send_item(OP_FAULT, 48'h0000_0000_7000, 1'b0, 1'b0);
      send_item(OP_FAULT, 48'h0000_0000_8000, 1'b0, 1'b0);
      send_item(OP_FLUSH, '0, 1'b0, 1'b0);

      configure(5'd1, 5'd0, 48'hFFFF_FFFF_FFFF);
      run_phase(50);
      configure(5'd4, 5'd30, rand48());
      run_phase(50);
      configure(5'd0, 5'd31, rand48());
      run_phase(45);
      configure(5'd20, 5'd5, rand48());
      run_phase(50);
      configure(5'd16, 5'($urandom_range(0, 30)), rand48());
      run_phase(55);
      configure(5'd3, 5'd12, '0);
      quiet = 1'b1;
      run_phase(50);

      req_valid <= 1'b0;
      wait_for_idle();
      if (tracker.pending_results.size() != 0) begin
         $display("%0t: leftover beats expected 0 actual %0d", $time,
                  tracker.pending_results.size());
         tracker.mismatches++;
      end
      if (tracker.mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
